FILE: rtl/core/tcf_pkg.sv
`default_nettype none

package tcf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam int TABLE_LEN = 24;
    localparam int TAB_IDX_W = 5;

    localparam int GYRO_FULL_SCALE_DPS = 2000;
    localparam int SAMPLE_PERIOD_MS    = 10;
    localparam int GYRO_GAIN           = GYRO_FULL_SCALE_DPS * SAMPLE_PERIOD_MS;
    localparam int GYRO_GAIN_W         = 19;

    // Integration divisor 128000 = 125 * 2^10.
    localparam int DIV_ODD   = 125;
    localparam int DIV_POW2  = 10;
    localparam int GYRO_DIV  = DIV_ODD << DIV_POW2;
    localparam int GYRO_DIV_W = 18;

    localparam int BLEND_SHIFT = 16;
    localparam int ANGLE_SHIFT = 8;

    localparam int SAMPLE_W = 16;
    localparam int XY_W     = 27;
    localparam int Z_W      = 27;
    localparam int ACC_W    = 19;
    localparam int GYRO_W   = 17;
    localparam int ANGLE_W  = 17;
    localparam int TRIM_W   = 13;
    localparam int WEIGHT_W = 16;
    localparam int LIMIT_W  = 16;

    localparam int ANGLE_MAX_INT = 46080;
    localparam int HALF_TURN_Z   = 180 * 65536;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GYRO_BIAS    = 3'd0,
        REG_ANGLE_TRIM   = 3'd1,
        REG_BLEND_WEIGHT = 3'd2,
        REG_FALL_LIMIT   = 3'd3
    } cfg_reg_t;

    localparam logic signed [SAMPLE_W-1:0] GYRO_BIAS_RST    = 16'sd16;
    localparam logic signed [TRIM_W-1:0]   ANGLE_TRIM_RST   = 13'sd128;
    localparam logic [WEIGHT_W-1:0]        BLEND_WEIGHT_RST = 16'd655;
    localparam logic [LIMIT_W-1:0]         FALL_LIMIT_RST   = 16'd12800;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] gyro_y;
    } tcf_in_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] tilt_angle;
        logic                      fallen;
    } tcf_out_t;

    typedef struct packed {
        logic signed [ACC_W-1:0]  acc;
        logic signed [GYRO_W-1:0] g;
    } tcf_mid_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] gyro_bias;
        logic signed [TRIM_W-1:0]   angle_trim;
        logic [WEIGHT_W-1:0]        blend_weight;
        logic [LIMIT_W-1:0]         fall_limit;
    } tcf_cfg_t;

    // Arctangent of 2^-i in units of 2^-16 degree.
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 27'sd2949120;
            5'd1:    v = 27'sd1740967;
            5'd2:    v = 27'sd919879;
            5'd3:    v = 27'sd466945;
            5'd4:    v = 27'sd234379;
            5'd5:    v = 27'sd117304;
            5'd6:    v = 27'sd58666;
            5'd7:    v = 27'sd29335;
            5'd8:    v = 27'sd14668;
            5'd9:    v = 27'sd7334;
            5'd10:   v = 27'sd3667;
            5'd11:   v = 27'sd1833;
            5'd12:   v = 27'sd917;
            5'd13:   v = 27'sd458;
            5'd14:   v = 27'sd229;
            5'd15:   v = 27'sd115;
            5'd16:   v = 27'sd57;
            5'd17:   v = 27'sd29;
            5'd18:   v = 27'sd14;
            5'd19:   v = 27'sd7;
            5'd20:   v = 27'sd4;
            5'd21:   v = 27'sd2;
            5'd22:   v = 27'sd1;
            default: v = 27'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tcf_queue.sv
`default_nettype none

module tcf_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = tcf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push_ok;
    logic             pop_ok;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tcf_front.sv
`default_nettype none

module tcf_front #(
    parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tcf_pkg::tcf_in_t  sample,
    output logic              full,
    input  tcf_pkg::tcf_cfg_t cfg,
    output logic              mid_push,
    output tcf_pkg::tcf_mid_t mid_word,
    input  logic              mid_full
);

    import tcf_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0]        CNT_LAST = CNT_W'(STEPS - 1);
    localparam logic signed [Z_W-1:0]   HALF_Z   = Z_W'(HALF_TURN_Z);
    localparam logic signed [Z_W:0]     ROUND_Z  = (Z_W+1)'(1 << (ANGLE_SHIFT - 1));

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROT,
        S_DONE,
        S_SEND
    } state_t;

    state_t                   state_reg, state_next;
    logic signed [XY_W-1:0]   x_reg, x_next;
    logic signed [XY_W-1:0]   y_reg, y_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     zero_reg, zero_next;
    logic signed [GYRO_W-1:0] g_reg, g_next;
    tcf_mid_t                 mid_reg, mid_next;

    logic signed [XY_W-1:0]   ax_w;
    logic signed [XY_W-1:0]   az_w;
    logic signed [XY_W-1:0]   xs;
    logic signed [XY_W-1:0]   ys;
    logic signed [Z_W-1:0]    tab;
    logic signed [Z_W-1:0]    z_fin;
    logic signed [Z_W:0]      z_round;

    assign full     = (state_reg != S_IDLE);
    assign mid_push = (state_reg == S_SEND);
    assign mid_word = mid_reg;

    always_comb
    begin
        ax_w    = XY_W'(sample.accel_x) <<< ANGLE_SHIFT;
        az_w    = XY_W'(sample.accel_z) <<< ANGLE_SHIFT;
        xs      = x_reg >>> cnt_reg;
        ys      = y_reg >>> cnt_reg;
        tab     = atan_entry(TAB_IDX_W'(cnt_reg));
        z_fin   = zero_reg ? '0 : z_reg;
        z_round = ROUND_Z - (Z_W+1)'(z_fin);

        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        cnt_next   = cnt_reg;
        zero_next  = zero_reg;
        g_next     = g_reg;
        mid_next   = mid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (push)
                begin
                    zero_next = (sample.accel_x == '0) && (sample.accel_z == '0);
                    g_next    = GYRO_W'(sample.gyro_y) - GYRO_W'(cfg.gyro_bias);
                    cnt_next  = '0;
                    // A vector in the left half plane is turned by half a turn first.
                    if (sample.accel_z[SAMPLE_W-1])
                    begin
                        x_next = -az_w;
                        y_next = -ax_w;
                        z_next = sample.accel_x[SAMPLE_W-1] ? -HALF_Z : HALF_Z;
                    end
                    else
                    begin
                        x_next = az_w;
                        y_next = ax_w;
                        z_next = '0;
                    end
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                if (!y_reg[XY_W-1])
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + tab;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - tab;
                end
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                mid_next.acc = ACC_W'(z_round >>> ANGLE_SHIFT) + ACC_W'(cfg.angle_trim);
                mid_next.g   = g_reg;
                state_next   = S_SEND;
            end
            S_SEND:
            begin
                if (!mid_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            cnt_reg   <= '0;
            zero_reg  <= 1'b0;
            g_reg     <= '0;
            mid_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            cnt_reg   <= cnt_next;
            zero_reg  <= zero_next;
            g_reg     <= g_next;
            mid_reg   <= mid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tcf_back.sv
`default_nettype none

module tcf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  tcf_pkg::tcf_cfg_t cfg,
    input  tcf_pkg::tcf_mid_t mid_word,
    input  logic              mid_empty,
    output logic              mid_pop,
    output logic              out_push,
    output tcf_pkg::tcf_out_t out_word,
    input  logic              out_full
);

    import tcf_pkg::*;

    localparam int MA_W  = ACC_W + WEIGHT_W + 1;
    localparam int MB_W  = ANGLE_W + WEIGHT_W + 2;
    localparam int MG_W  = GYRO_W + WEIGHT_W + 2;
    localparam int P_W   = MA_W + 1;
    localparam int H_W   = MG_W + GYRO_GAIN_W;
    localparam int T_W   = P_W + GYRO_DIV_W;
    localparam int N_W   = T_W + 1;
    localparam int N3_W  = 28;
    localparam int RM_W  = 29;
    localparam int PR_W  = N3_W + RM_W;
    localparam int Q_W   = 22;
    localparam int RECIP_K    = 35;
    localparam int NORM_SHIFT = BLEND_SHIFT + DIV_POW2;
    localparam int Q_OFFSET   = 1 << 20;

    localparam longint D_FULL    = longint'(GYRO_DIV) << BLEND_SHIFT;
    localparam longint N_BIAS    = D_FULL / 2 + D_FULL * Q_OFFSET;
    localparam longint RECIP_INT = ((longint'(1) << RECIP_K) + DIV_ODD - 1) / DIV_ODD;

    localparam logic signed [GYRO_GAIN_W-1:0] GAIN_S  = GYRO_GAIN_W'(GYRO_GAIN);
    localparam logic signed [GYRO_DIV_W-1:0]  DIV_S   = GYRO_DIV_W'(GYRO_DIV);
    localparam logic signed [N_W-1:0]         BIAS_S  = N_W'(N_BIAS);
    localparam logic [RM_W-1:0]               RECIP_M = RM_W'(RECIP_INT);
    localparam logic signed [Q_W-1:0]         Q_OFF_S = Q_W'(Q_OFFSET);
    localparam logic signed [Q_W-1:0]         Q_MAX   = Q_W'(ANGLE_MAX_INT);
    localparam logic signed [ANGLE_W-1:0]     ANG_MAX = ANGLE_W'(ANGLE_MAX_INT);
    localparam logic signed [WEIGHT_W+1:0]    ONE_W   = (WEIGHT_W+2)'(1 << BLEND_SHIFT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_SCALE,
        S_NORM,
        S_RECIP,
        S_FIN,
        S_SEND
    } state_t;

    state_t                    state_reg, state_next;
    logic signed [MA_W-1:0]    ma_reg, ma_next;
    logic signed [MB_W-1:0]    mb_reg, mb_next;
    logic signed [MG_W-1:0]    mg_reg, mg_next;
    logic signed [P_W-1:0]     p_reg, p_next;
    logic signed [H_W-1:0]     h_reg, h_next;
    logic signed [T_W-1:0]     t_reg, t_next;
    logic [N3_W-1:0]           n3_reg, n3_next;
    logic [PR_W-1:0]           prod_reg, prod_next;
    logic signed [ANGLE_W-1:0] est_reg, est_next;
    tcf_out_t                  res_reg, res_next;

    logic signed [WEIGHT_W:0]   alpha_s;
    logic signed [WEIGHT_W+1:0] beta_s;
    logic signed [N_W-1:0]      n_sum;
    logic signed [Q_W-1:0]      q_s;
    logic signed [ANGLE_W-1:0]  ang;
    logic [ANGLE_W-1:0]         mag;

    assign mid_pop  = (state_reg == S_IDLE) && !mid_empty;
    assign out_push = (state_reg == S_SEND);
    assign out_word = res_reg;

    always_comb
    begin
        alpha_s = $signed({1'b0, cfg.blend_weight});
        beta_s  = ONE_W - $signed({2'b00, cfg.blend_weight});
        n_sum   = N_W'(t_reg) + N_W'(h_reg) + BIAS_S;
        q_s     = $signed(prod_reg[RECIP_K +: Q_W]) - Q_OFF_S;
        if (q_s > Q_MAX)
        begin
            ang = ANG_MAX;
        end
        else if (q_s < -Q_MAX)
        begin
            ang = -ANG_MAX;
        end
        else
        begin
            ang = ANGLE_W'(q_s);
        end
        mag = ang[ANGLE_W-1] ? ANGLE_W'(-ang) : ANGLE_W'(ang);

        state_next = state_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        mg_next    = mg_reg;
        p_next     = p_reg;
        h_next     = h_reg;
        t_next     = t_reg;
        n3_next    = n3_reg;
        prod_next  = prod_reg;
        est_next   = est_reg;
        res_next   = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (!mid_empty)
                begin
                    ma_next    = alpha_s * mid_word.acc;
                    mb_next    = beta_s * est_reg;
                    mg_next    = beta_s * mid_word.g;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                p_next     = P_W'(ma_reg) + P_W'(mb_reg);
                h_next     = mg_reg * GAIN_S;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                t_next     = p_reg * DIV_S;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                // The bias keeps the sum positive so the odd divisor can use a reciprocal.
                n3_next    = n_sum[NORM_SHIFT +: N3_W];
                state_next = S_RECIP;
            end
            S_RECIP:
            begin
                prod_next  = n3_reg * RECIP_M;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                est_next            = ang;
                res_next.tilt_angle = ang;
                res_next.fallen     = (mag > {1'b0, cfg.fall_limit});
                state_next          = S_SEND;
            end
            S_SEND:
            begin
                if (!out_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ma_reg    <= '0;
            mb_reg    <= '0;
            mg_reg    <= '0;
            p_reg     <= '0;
            h_reg     <= '0;
            t_reg     <= '0;
            n3_reg    <= '0;
            prod_reg  <= '0;
            est_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ma_reg    <= ma_next;
            mb_reg    <= mb_next;
            mg_reg    <= mg_next;
            p_reg     <= p_next;
            h_reg     <= h_next;
            t_reg     <= t_next;
            n3_reg    <= n3_next;
            prod_reg  <= prod_next;
            est_reg   <= est_next;
            res_reg   <= res_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_FIN) |=> $stable(est_reg))
        else $error("angle estimate changed outside the final step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEND) |-> (res_reg.tilt_angle == est_reg))
        else $error("result word differs from the stored angle estimate");

    assert property (@(posedge clk) disable iff (!rst_n)
        (est_reg <= ANG_MAX) && (est_reg >= -ANG_MAX))
        else $error("angle estimate outside the saturation range");

    assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |=> (state_reg == S_SUM))
        else $error("queue word taken without starting the blend");

endmodule

`default_nettype wire

FILE: rtl/core/tilt_complementary_filter_top.sv
`default_nettype none

// Channel   Handshake                Word
// sample    push / full              accel_x, accel_z, gyro_y (16 bit signed each)
// result    pop / empty              tilt_angle (17 bit signed), fallen
// config    cfg_valid / cfg_ready    cfg_index (3 bit), cfg_data (16 bit)
//
// The front CORDIC stays full from accept through its rotation, done and send states,
// which sets the sustained rate; the back blend (sum, scale, norm, reciprocal, final and
// send states) overlaps the next sample.
// Reset clears the angle estimate to zero, loads the register defaults and empties queues.
// A word queue between front and back and a result queue let either side stall alone.

module tilt_complementary_filter_top #(
    parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF,
    parameter int QUEUE_DEPTH  = tcf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  tcf_pkg::tcf_in_t                 sample,
    output logic                             full,
    input  logic                             pop,
    output tcf_pkg::tcf_out_t                result,
    output logic                             empty,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import tcf_pkg::*;

    localparam int MID_W = $bits(tcf_mid_t);
    localparam int OUT_W = $bits(tcf_out_t);

    tcf_cfg_t          cfg_reg, cfg_next;
    logic              mid_push;
    tcf_mid_t          mid_wr;
    logic              mid_full;
    logic [MID_W-1:0]  mid_rdata;
    tcf_mid_t          mid_rd;
    logic              mid_empty;
    logic              mid_pop;
    logic              out_push;
    tcf_out_t          out_wr;
    logic              out_full;
    logic [OUT_W-1:0]  out_rdata;

    assign cfg_ready = 1'b1;
    assign mid_rd    = tcf_mid_t'(mid_rdata);
    assign result    = tcf_out_t'(out_rdata);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GYRO_BIAS:    cfg_next.gyro_bias    = $signed(cfg_data);
                REG_ANGLE_TRIM:   cfg_next.angle_trim   = $signed(cfg_data[TRIM_W-1:0]);
                REG_BLEND_WEIGHT: cfg_next.blend_weight = cfg_data;
                REG_FALL_LIMIT:   cfg_next.fall_limit   = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gyro_bias    <= GYRO_BIAS_RST;
            cfg_reg.angle_trim   <= ANGLE_TRIM_RST;
            cfg_reg.blend_weight <= BLEND_WEIGHT_RST;
            cfg_reg.fall_limit   <= FALL_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tcf_front #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .sample   (sample),
        .full     (full),
        .cfg      (cfg_reg),
        .mid_push (mid_push),
        .mid_word (mid_wr),
        .mid_full (mid_full)
    );

    tcf_queue #(
        .WIDTH (MID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wr),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    tcf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_word  (mid_rd),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .out_push  (out_push),
        .out_word  (out_wr),
        .out_full  (out_full)
    );

    tcf_queue #(
        .WIDTH (OUT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wr),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

endmodule

`default_nettype wire
